>>> hdl/lwbc_pkg.sv
// Shared types and constants of the cache tag and policy engine.
`timescale 1ns / 1ps

package lwbc_pkg;

    localparam int CACHE_SLOTS       = 16;
    localparam int SECTORS_PER_BLOCK = 8;
    localparam int SLOT_W            = 4;
    localparam int IDX_W             = SLOT_W + 1;
    localparam int OFF_W             = 3;

    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_FLUSH     = 3'd2;
    localparam logic [2:0] CMD_INVAL     = 3'd3;
    localparam logic [2:0] CMD_FILL_FAIL = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_DEV = 2'd1;
    localparam logic [1:0] ST_NOTHING = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  dev_sel;
        logic [31:0] sector_lba;
        logic [15:0] sectors_left;
        logic [3:0]  slot_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  slot;
        logic        need_fill;
        logic        writeback;
        logic [2:0]  wb_device;
        logic [31:0] wb_block;
        logic [31:0] req_block;
        logic [2:0]  offset;
        logic [3:0]  copy_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        dirty;
        logic [2:0]  device;
        logic [31:0] block;
        logic [31:0] stamp;
    } t_entry;

endpackage

>>> hdl/lwbc_tag_ram.sv
// Tag memory: one entry per cache slot, one read and one write port.
`timescale 1ns / 1ps

module lwbc_tag_ram (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [lwbc_pkg::SLOT_W-1:0] i_rd_addr,
    output lwbc_pkg::t_entry            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [lwbc_pkg::SLOT_W-1:0] i_wr_addr,
    input  lwbc_pkg::t_entry            i_wr_data
);
    import lwbc_pkg::*;

    t_entry r_mem [CACHE_SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/lru_writeback_block_cache_tags_top.sv
// Top level of the cache tag and policy engine: control sequencer and state.
`timescale 1ns / 1ps

// This engine keeps the tags of a 16-slot fully associative write-back sector
// cache with LRU replacement; it moves no sector data. Entry tags, dirty flags
// and access stamps sit in a one-read, one-write tag memory with a registered
// read; valid bits are flip-flops cleared by reset. Read and write requests
// sweep all slots through the memory read port, one slot per cycle, then
// update the chosen slot and emit the lookup word. Flush and invalidate take
// the same sweep and emit one writeback word per dirty block of the device,
// or one status word when there is none (the sweep pauses whenever a writeback
// word cannot be handed on); fill-failed, unknown-command, bad-device and
// zero-count read or write requests answer without a sweep, their word being
// registered at the edge that accepts them. A new request is taken only when
// the previous one has finished and its final word has left the result
// register or is leaving it in that same cycle.

module lru_writeback_block_cache_tags_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [7:0]     i_cfg_wr_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lwbc_pkg::t_in  i_in_word,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lwbc_pkg::t_out o_out_word
);
    import lwbc_pkg::*;

    // Control and request state.
    t_state                r_state, n_state;
    logic [7:0]            r_mask;
    logic [CACHE_SLOTS-1:0] r_valid, n_valid;
    logic [31:0]           r_clock, n_clock;
    t_in                   r_req, n_req;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_ev, n_ev;
    logic [SLOT_W-1:0]     r_ev_idx, n_ev_idx;

    // Lookup tracking.
    logic                  r_hit, n_hit;
    logic [SLOT_W-1:0]     r_hit_idx, n_hit_idx;
    t_entry                r_hit_e, n_hit_e;
    logic [SLOT_W-1:0]     r_min_idx, n_min_idx;
    t_entry                r_min_e, n_min_e;

    // Flush: one writeback held back so the final one can carry last.
    logic                  r_pend_v, n_pend_v;
    logic [SLOT_W-1:0]     r_pend_slot, n_pend_slot;
    logic [2:0]            r_pend_dev, n_pend_dev;
    logic [31:0]           r_pend_blk, n_pend_blk;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    // Memory ports.
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    t_entry                rd_data;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    t_entry                wr_data;

    logic                  out_free;
    logic                  accept;
    logic                  flush_mode;
    logic                  match_dirty;
    logic                  freeze;
    logic                  dev_eq;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [OFF_W-1:0]      off;
    logic [31:0]           blk;
    logic [3:0]            avail;
    logic [3:0]            copy;
    logic [SLOT_W-1:0]     sel;
    logic [31:0]           clk_inc;

    lwbc_tag_ram u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign flush_mode  = (r_req.command == CMD_FLUSH) || (r_req.command == CMD_INVAL);
    assign dev_eq      = rd_data.device == r_req.dev_sel;
    assign match_dirty = r_valid[r_ev_idx] && rd_data.dirty && dev_eq;
    // A second dirty block cannot be taken while the held one has nowhere to go.
    assign freeze      = (r_state == S_SCAN) && r_ev && flush_mode && match_dirty
                         && r_pend_v && !out_free;

    // Request geometry, from the registered request.
    assign off     = r_req.sector_lba[OFF_W-1:0];
    assign blk     = {r_req.sector_lba[31:OFF_W], {OFF_W{1'b0}}};
    assign avail   = 4'(SECTORS_PER_BLOCK) - {1'b0, off};
    assign copy    = (r_req.sectors_left < {12'd0, avail}) ? r_req.sectors_left[3:0] : avail;
    assign clk_inc = r_clock + 32'd1;

    // First free slot from the valid bits.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_clock     = r_clock;
        n_req       = r_req;
        n_idx       = r_idx;
        n_ev        = r_ev;
        n_ev_idx    = r_ev_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_e     = r_hit_e;
        n_min_idx   = r_min_idx;
        n_min_e     = r_min_e;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_dev  = r_pend_dev;
        n_pend_blk  = r_pend_blk;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_idx[SLOT_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_ev_idx;
        wr_data     = rd_data;
        sel         = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req       = i_in_word;
                    n_idx       = '0;
                    n_ev        = 1'b0;
                    n_hit       = 1'b0;
                    n_pend_v    = 1'b0;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (i_in_word.command == CMD_FILL_FAIL) begin
                        n_valid[i_in_word.slot_index] = 1'b0;
                        n_out.slot  = i_in_word.slot_index;
                        n_out_valid = 1'b1;
                    end else if (i_in_word.command > CMD_FILL_FAIL) begin
                        n_out.status = ST_NOTHING;
                        n_out_valid  = 1'b1;
                    end else if (!r_mask[i_in_word.dev_sel]) begin
                        n_out.status = ST_BAD_DEV;
                        n_out_valid  = 1'b1;
                    end else if (i_in_word.command == CMD_FLUSH
                                 || i_in_word.command == CMD_INVAL) begin
                        n_state = S_SCAN;
                    end else if (i_in_word.sectors_left == 16'd0) begin
                        n_out.status = ST_NOTHING;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (!freeze) begin
                    // Issue the next slot read.
                    if (r_idx < IDX_W'(CACHE_SLOTS)) begin
                        rd_en    = 1'b1;
                        n_ev     = 1'b1;
                        n_ev_idx = r_idx[SLOT_W-1:0];
                        n_idx    = r_idx + IDX_W'(1);
                    end else begin
                        n_ev = 1'b0;
                    end
                    // Evaluate the slot whose read was issued last.
                    if (r_ev) begin
                        if (flush_mode) begin
                            if (match_dirty) begin
                                if (r_pend_v) begin
                                    n_out              = '0;
                                    n_out.slot         = r_pend_slot;
                                    n_out.writeback    = 1'b1;
                                    n_out.wb_device    = r_pend_dev;
                                    n_out.wb_block     = r_pend_blk;
                                    n_out_valid        = 1'b1;
                                end
                                n_pend_v      = 1'b1;
                                n_pend_slot   = r_ev_idx;
                                n_pend_dev    = rd_data.device;
                                n_pend_blk    = rd_data.block;
                                wr_en         = 1'b1;
                                wr_data.dirty = 1'b0;
                            end
                            if (r_req.command == CMD_INVAL && r_valid[r_ev_idx] && dev_eq) begin
                                n_valid[r_ev_idx] = 1'b0;
                            end
                        end else begin
                            if (!r_hit && r_valid[r_ev_idx] && dev_eq && rd_data.block == blk)
                            begin
                                n_hit     = 1'b1;
                                n_hit_idx = r_ev_idx;
                                n_hit_e   = rd_data;
                            end
                            if (r_ev_idx == '0 || rd_data.stamp < r_min_e.stamp) begin
                                n_min_idx = r_ev_idx;
                                n_min_e   = rd_data;
                            end
                        end
                    end else if (r_idx == IDX_W'(CACHE_SLOTS)) begin
                        // Sweep finished.
                        if (!flush_mode) begin
                            n_state = S_UPD;
                        end else if (out_free) begin
                            n_out       = '0;
                            n_out.last  = 1'b1;
                            if (r_pend_v) begin
                                n_out.slot         = r_pend_slot;
                                n_out.writeback    = 1'b1;
                                n_out.wb_device    = r_pend_dev;
                                n_out.wb_block     = r_pend_blk;
                            end
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                end
            end

            S_UPD: begin
                if (out_free) begin
                    n_out                 = '0;
                    n_out.status          = ST_OK;
                    n_out.req_block       = blk;
                    n_out.offset          = off;
                    n_out.copy_count      = copy;
                    n_out.last            = 1'b1;
                    wr_data.device        = r_req.dev_sel;
                    wr_data.block         = blk;
                    wr_data.stamp         = clk_inc;
                    if (r_hit) begin
                        sel           = r_hit_idx;
                        n_out.hit     = 1'b1;
                        wr_data.dirty = r_hit_e.dirty || (r_req.command == CMD_WRITE);
                    end else begin
                        if (free_found) begin
                            sel = free_idx;
                        end else begin
                            sel = r_min_idx;
                            // A dirty victim of an unregistered device is dropped.
                            if (r_min_e.dirty && r_mask[r_min_e.device]) begin
                                n_out.writeback    = 1'b1;
                                n_out.wb_device    = r_min_e.device;
                                n_out.wb_block     = r_min_e.block;
                            end
                        end
                        wr_data.dirty   = r_req.command == CMD_WRITE;
                        n_out.need_fill = (r_req.command == CMD_READ) || (off != '0)
                                          || (r_req.sectors_left < 16'(SECTORS_PER_BLOCK));
                        n_valid[sel]    = 1'b1;
                    end
                    n_out.slot  = sel;
                    wr_addr     = sel;
                    wr_en       = 1'b1;
                    n_clock     = clk_inc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_valid     <= '0;
            r_clock     <= '0;
            r_ev        <= 1'b0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= i_cfg_wr_en ? i_cfg_wr_data : r_mask;
            r_valid     <= n_valid;
            r_clock     <= n_clock;
            r_ev        <= n_ev;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_ev_idx    <= n_ev_idx;
        r_hit_idx   <= n_hit_idx;
        r_hit_e     <= n_hit_e;
        r_min_idx   <= n_min_idx;
        r_min_e     <= n_min_e;
        r_pend_slot <= n_pend_slot;
        r_pend_dev  <= n_pend_dev;
        r_pend_blk  <= n_pend_blk;
        r_out       <= n_out;
    end

endmodule

>>> dv/tb.sv
// Self-checking testbench of the cache tag and policy engine.
`timescale 1ns / 1ps

module tb;
    import lwbc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;

    // Tracks the tag state of the engine and predicts the words it returns.
    class tag_policy_tracker;
        logic [7:0]  active_mask;
        logic        valid_q [CACHE_SLOTS];
        logic        dirty_q [CACHE_SLOTS];
        logic [2:0]  device_q [CACHE_SLOTS];
        logic [31:0] block_q [CACHE_SLOTS];
        logic [31:0] stamp_q [CACHE_SLOTS];
        logic [31:0] stamp_counter;
        t_out        expected_words[$];
        int          errors;

        function new();
            active_mask   = '0;
            stamp_counter = '0;
            errors        = 0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                valid_q[i]  = 1'b0;
                dirty_q[i]  = 1'b0;
                device_q[i] = '0;
                block_q[i]  = '0;
                stamp_q[i]  = '0;
            end
        endfunction

        function bit device_on(logic [2:0] d);
            return active_mask[d];
        endfunction

        function t_out status_word(logic [1:0] st);
            t_out w;
            w        = '0;
            w.status = st;
            w.last   = 1'b1;
            return w;
        endfunction

        // Works out every word that one accepted request causes.
        function void note_request(t_in req);
            t_out        w;
            int          n;
            int          s;
            bit          found;
            logic [2:0]  off;
            logic [31:0] blk;
            int          avail;
            if (req.command == CMD_FILL_FAIL) begin
                valid_q[req.slot_index] = 1'b0;
                w      = '0;
                w.slot = req.slot_index;
                w.last = 1'b1;
                expected_words.push_back(w);
                return;
            end
            if (req.command > CMD_FILL_FAIL) begin
                expected_words.push_back(status_word(ST_NOTHING));
                return;
            end
            if (!device_on(req.dev_sel)) begin
                expected_words.push_back(status_word(ST_BAD_DEV));
                return;
            end
            if (req.command == CMD_FLUSH || req.command == CMD_INVAL) begin
                n = 0;
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if (valid_q[i] && dirty_q[i] && device_q[i] == req.dev_sel) begin
                        w              = '0;
                        w.slot         = i[3:0];
                        w.writeback    = 1'b1;
                        w.wb_device    = device_q[i];
                        w.wb_block     = block_q[i];
                        expected_words.push_back(w);
                        dirty_q[i] = 1'b0;
                        n++;
                    end
                end
                if (req.command == CMD_INVAL) begin
                    for (int i = 0; i < CACHE_SLOTS; i++)
                        if (device_q[i] == req.dev_sel) valid_q[i] = 1'b0;
                end
                if (n == 0) expected_words.push_back(status_word(ST_OK));
                else expected_words[$].last = 1'b1;
                return;
            end
            if (req.sectors_left == 0) begin
                expected_words.push_back(status_word(ST_NOTHING));
                return;
            end
            off   = req.sector_lba[2:0];
            blk   = {req.sector_lba[31:3], 3'b000};
            avail = SECTORS_PER_BLOCK - off;
            w     = '0;
            s     = 0;
            found = 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (!found && valid_q[i] && device_q[i] == req.dev_sel
                        && block_q[i] == blk) begin
                    s     = i;
                    found = 1'b1;
                end
            end
            stamp_counter = stamp_counter + 1;
            if (found) begin
                w.hit = 1'b1;
            end else begin
                s = -1;
                for (int i = CACHE_SLOTS - 1; i >= 0; i--)
                    if (!valid_q[i]) s = i;
                if (s < 0) begin
                    // Every slot is in use: evict the least recently used one.
                    s = 0;
                    for (int i = 1; i < CACHE_SLOTS; i++)
                        if (stamp_q[i] < stamp_q[s]) s = i;
                    if (dirty_q[s] && device_on(device_q[s])) begin
                        w.writeback    = 1'b1;
                        w.wb_device    = device_q[s];
                        w.wb_block     = block_q[s];
                    end
                end
                valid_q[s]  = 1'b1;
                dirty_q[s]  = 1'b0;
                device_q[s] = req.dev_sel;
                block_q[s]  = blk;
                if (req.command == CMD_READ || off != 0 || req.sectors_left < SECTORS_PER_BLOCK)
                    w.need_fill = 1'b1;
            end
            stamp_q[s] = stamp_counter;
            if (req.command == CMD_WRITE) dirty_q[s] = 1'b1;
            w.status          = ST_OK;
            w.slot            = s[3:0];
            w.req_block       = blk;
            w.offset          = off;
            w.copy_count      = (req.sectors_left < avail) ? req.sectors_left[3:0] : avail[3:0];
            w.last            = 1'b1;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                $error("field %s: expected %0h, actual %0h", name, e, a);
                errors++;
            end
        endfunction

        // Compares one word taken from the engine with the oldest prediction.
        function void check_word(t_out got);
            t_out e;
            if (expected_words.size() == 0) begin
                $error("result word with no prediction pending: %h", got);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("hit", e.hit, got.hit);
            compare_field("slot", e.slot, got.slot);
            compare_field("need_fill", e.need_fill, got.need_fill);
            compare_field("writeback", e.writeback, got.writeback);
            compare_field("wb_device", e.wb_device, got.wb_device);
            compare_field("wb_block", e.wb_block, got.wb_block);
            compare_field("req_block", e.req_block, got.req_block);
            compare_field("offset", e.offset, got.offset);
            compare_field("copy_count", e.copy_count, got.copy_count);
            compare_field("last", e.last, got.last);
        endfunction
    endclass

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = '0;
    logic i_in_valid    = 1'b0;
    logic o_in_stall;
    t_in  i_in_word     = '0;
    logic o_out_valid;
    logic i_out_stall   = 1'b0;
    t_out o_out_word;

    tag_policy_tracker tracker = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    int cycle_count     = 0;
    logic [31:0] lba_base = '0;

    lru_writeback_block_cache_tags_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lru_writeback_block_cache_tags_top] ERROR");
            $finish;
        end
    end

    // Receiver side. The word is checked with the values seen just before the edge,
    // then the stall for the next cycle is chosen. A long hold-off is counted here
    // so that the engine backs up and stalls its own input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_word(o_out_word);
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // The mask is only written while the engine is idle, so the prediction
    // can take the new value at once.
    task automatic write_mask(logic [7:0] m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.active_mask = m;
    endtask

    // Offers one request word and returns at the edge that takes it. Valid is
    // only lowered inside an idle gap, so back-to-back words never see it drop.
    task automatic send_request(t_in req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= req;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(req);
    endtask

    // Lets every predicted word arrive, then lets the bench settle with no request offered.
    // Valid drops right at the edge that took the last word.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in make_request(logic [2:0] cmd, logic [2:0] dev,
                                         logic [31:0] lba, logic [15:0] cnt,
                                         logic [3:0] sidx);
        t_in r;
        r.command      = cmd;
        r.dev_sel      = dev;
        r.sector_lba   = lba;
        r.sectors_left = cnt;
        r.slot_index   = sidx;
        return r;
    endfunction

    // Mostly requests to a small set of blocks on active devices, so that hits,
    // evictions and flushes with dirty blocks happen often.
    function automatic t_in random_request();
        int          pick;
        logic [2:0]  cmd;
        logic [2:0]  dev;
        logic [31:0] lba;
        logic [15:0] cnt;
        pick = $urandom_range(99);
        if (pick < 40) cmd = CMD_READ;
        else if (pick < 75) cmd = CMD_WRITE;
        else if (pick < 83) cmd = CMD_FLUSH;
        else if (pick < 89) cmd = CMD_INVAL;
        else if (pick < 95) cmd = CMD_FILL_FAIL;
        else cmd = 3'($urandom_range(5, 7));
        dev = 3'($urandom_range(7));
        if (tracker.active_mask != 0 && $urandom_range(99) < 88) begin
            while (!tracker.active_mask[dev]) dev = 3'($urandom_range(7));
        end
        if ($urandom_range(99) < 10) lba = $urandom;
        else lba = lba_base + 32'($urandom_range(23)) * 8 + 32'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 5) cnt = '0;
        else if (pick < 15) cnt = 16'($urandom_range(65535));
        else cnt = 16'($urandom_range(1, 12));
        return make_request(cmd, dev, lba, cnt, 4'($urandom_range(15)));
    endfunction

    task automatic run_phase(int count, int idle_pct, int stall_pct, logic [7:0] m);
        write_mask(m);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        lba_base        = $urandom;
        for (int i = 0; i < count; i++) send_request(random_request());
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no device registered every request is refused.
        send_request(make_request(CMD_READ, 3'd0, 32'd0, 16'd1, 4'd0));
        send_request(make_request(CMD_FLUSH, 3'd7, 32'd0, 16'd0, 4'd0));
        drain_results();
        write_mask(8'hFF);
        send_request(make_request(CMD_READ, 3'd0, 32'd0, 16'd0, 4'd0));
        send_request(make_request(CMD_READ, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
        send_request(make_request(CMD_WRITE, 3'd1, 32'h0000_0010, 16'd8, 4'd0));
        send_request(make_request(CMD_WRITE, 3'd1, 32'h0000_0023, 16'd1, 4'd0));
        send_request(make_request(CMD_WRITE, 3'd1, 32'h0000_0010, 16'd3, 4'd0));
        send_request(make_request(CMD_READ, 3'd7, 32'hFFFF_FFF8, 16'd2, 4'd0));
        send_request(make_request(CMD_FLUSH, 3'd1, 32'd0, 16'd0, 4'd0));
        send_request(make_request(CMD_FLUSH, 3'd1, 32'd0, 16'd0, 4'd0));
        send_request(make_request(CMD_WRITE, 3'd2, 32'h0000_0040, 16'd5, 4'd0));
        send_request(make_request(CMD_INVAL, 3'd2, 32'd0, 16'd0, 4'd0));
        send_request(make_request(CMD_FILL_FAIL, 3'd0, 32'd0, 16'd0, 4'd15));
        send_request(make_request(CMD_FILL_FAIL, 3'd0, 32'd0, 16'd0, 4'd0));
        send_request(make_request(3'd5, 3'd0, 32'd0, 16'd1, 4'd0));
        send_request(make_request(3'd7, 3'd0, 32'd0, 16'd1, 4'd0));
        // Fill every slot with dirty blocks of device 3, then drop the device so
        // the evicted dirty blocks are discarded without a writeback.
        for (int i = 0; i < CACHE_SLOTS; i++)
            send_request(make_request(CMD_WRITE, 3'd3, 32'h1000 + 32'(i) * 8, 16'd8, 4'd0));
        drain_results();
        write_mask(8'hF7);
        send_request(make_request(CMD_READ, 3'd4, 32'h2000, 16'd4, 4'd0));
        send_request(make_request(CMD_READ, 3'd4, 32'h2008, 16'd4, 4'd0));
        drain_results();

        // Random part. The first phase opens with a long receiver hold-off
        // while words keep being offered.
        hold_request = 1'b1;
        run_phase(80, 0, 0, 8'hFF);
        run_phase(80, 86, 0, 8'($urandom));
        run_phase(80, 0, 86, 8'h5A);
        run_phase(80, 11, 11, 8'hA5);
        run_phase(60, 0, 0, 8'($urandom));

        if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
            $display("[lru_writeback_block_cache_tags_top] OK");
        end else begin
            $display("[lru_writeback_block_cache_tags_top] ERROR");
        end
        $finish;
    end

endmodule
